FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the duty capture RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held.
`define PDCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define PDCS_NEVER(lbl, expr, msg) \
  `PDCS_ASSERT(lbl, !(expr), msg)

`endif

FILE: hw/rtl/pdcs_pkg.sv
// Shared types and constants for the PWM duty capture sequencer.
// No dependencies; imported by every module and interface of the block.
package pdcs_pkg;

  localparam int FIELD_W   = 16;
  localparam int PPC_W     = 15;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_STEPS = FIELD_W;
  localparam int STEP_W    = $clog2(MUL_STEPS);

  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CAPTURE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PPC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FS    = 2'd3;

  localparam logic [PPC_W-1:0]   PPC_RST   = 15'd10;
  localparam logic [FIELD_W-1:0] RECAL_RST = 16'd100;
  localparam logic [FIELD_W-1:0] THR_RST   = 16'd2;
  localparam logic [FIELD_W-1:0] FS_RST    = 16'd1000;

  typedef struct packed {
    logic              go;
    logic [MODE_W-1:0] mode;
  } pdcs_cmd_t;

  typedef struct packed {
    logic falling;
    logic rearm;
  } pdcs_seq_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pdcs_mdu_stat_t;

endpackage

FILE: hw/rtl/pdcs_if.sv
// Valid/ready channel interfaces: input item, result item, register write.
// Depends on pdcs_pkg for field widths.
interface pdcs_in_if import pdcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [FIELD_W-1:0] slave_stamp;
  logic [FIELD_W-1:0] master_stamp;

  modport source (output valid, mode, slave_stamp, master_stamp, input ready);
  modport sink   (input valid, mode, slave_stamp, master_stamp, output ready);
endinterface

interface pdcs_out_if import pdcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] duty;
  logic               full_or_empty;
  logic               edge_falling;
  logic               rearm;

  modport source (output valid, duty, full_or_empty, edge_falling, rearm, input ready);
  modport sink   (input valid, duty, full_or_empty, edge_falling, rearm, output ready);
endinterface

interface pdcs_cfg_if import pdcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/pdcs_seq.sv
// Phase sequencer: sequence counter, edge selection, period/duration capture.
// Depends on pdcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pdcs_seq import pdcs_pkg::*; #(
  parameter int SW = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pdcs_cmd_t          cmd,
  input  logic [SW-1:0]      slave_i,
  input  logic [SW-1:0]      master_i,
  input  logic [PPC_W-1:0]   ppc_i,
  input  logic [FIELD_W-1:0] recal_i,
  output pdcs_seq_stat_t     stat,
  output logic [SW-1:0]      period_o,
  output logic [SW-1:0]      duration_o
);

  logic [FIELD_W-1:0] cnt_r, cnt_nxt;
  logic               falling_r, falling_nxt;
  logic [SW-1:0]      per_r, per_nxt;
  logic [SW-1:0]      dur_r, dur_nxt;
  logic [SW-1:0]      diff;
  logic               rearm;
  logic               at_zero, at_ppc;

  always_comb begin
    cnt_nxt     = cnt_r;
    falling_nxt = falling_r;
    per_nxt     = per_r;
    dur_nxt     = dur_r;
    rearm       = 1'b0;
    diff        = master_i - slave_i;
    at_zero     = (cnt_r == '0);
    at_ppc      = (cnt_r == FIELD_W'(ppc_i));
    if (cmd.go) begin
      unique case (cmd.mode)
        MODE_TICK: begin
          if (at_zero) begin
            falling_nxt = 1'b0;
            rearm       = 1'b1;
            cnt_nxt     = cnt_r + 16'd1;
          end else if (at_ppc) begin
            falling_nxt = 1'b1;
            rearm       = 1'b1;
            cnt_nxt     = cnt_r + 16'd1;
          end
        end
        MODE_CAPTURE: begin
          // at zero or at the phase boundary the channel is about to be re-armed
          if (!at_zero && !at_ppc) begin
            if (cnt_r < FIELD_W'(ppc_i)) begin
              per_nxt = diff;
              cnt_nxt = cnt_r + 16'd1;
            end else begin
              dur_nxt = diff;
              cnt_nxt = (cnt_r > recal_i) ? '0 : cnt_r + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      falling_r <= 1'b0;
      per_r     <= '0;
      dur_r     <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      falling_r <= falling_nxt;
      per_r     <= per_nxt;
      dur_r     <= dur_nxt;
    end
  end

  assign stat.falling = falling_r;
  assign stat.rearm   = rearm;
  assign period_o     = per_r;
  assign duration_o   = dur_r;

  `PDCS_ASSERT(a_fall_rearm, $rose(falling_r) |-> $past(rearm), "falling edge armed without rearm")
  `PDCS_ASSERT(a_cnt_idle, !$past(cmd.go) |-> $stable(cnt_r), "sequence count moved without a command")

endmodule

FILE: hw/rtl/pdcs_mdu.sv
// Bit-serial multiply then restoring divide: q = sat16(a * b / d).
// Depends on pdcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pdcs_mdu import pdcs_pkg::*; #(
  parameter int SW = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SW-1:0]      mcand_i,
  input  logic [FIELD_W-1:0] mplier_i,
  input  logic [SW-1:0]      divisor_i,
  output pdcs_mdu_stat_t     stat,
  output logic [FIELD_W-1:0] quot_o
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_CHK  = 2'd2;
  localparam logic [1:0] M_DIV  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [SW-1:0]      hi_r, hi_nxt;
  logic [FIELD_W-1:0] lo_r, lo_nxt;
  logic [SW-1:0]      mc_r, mc_nxt;
  logic [SW-1:0]      d_r, d_nxt;
  logic               done_r, done_nxt;
  logic [SW:0]        sum;
  logic [SW:0]        trial;
  logic [SW:0]        rem;
  logic               ge;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    mc_nxt    = mc_r;
    d_nxt     = d_r;
    done_nxt  = 1'b0;
    sum       = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mc_r} : '0);
    trial     = {hi_r, lo_r[FIELD_W-1]};
    rem       = trial - {1'b0, d_r};
    ge        = (trial >= {1'b0, d_r});
    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          hi_nxt    = '0;
          lo_nxt    = mplier_i;
          mc_nxt    = mcand_i;
          d_nxt     = divisor_i;
          cnt_nxt   = '0;
          state_nxt = M_MUL;
        end
      end
      M_MUL: begin
        // product shifts right through {hi, lo}, one multiplier bit a cycle
        hi_nxt  = sum[SW:1];
        lo_nxt  = {sum[0], lo_r[FIELD_W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(MUL_STEPS - 1)) state_nxt = M_CHK;
      end
      M_CHK: begin
        // high half >= divisor means the quotient needs more than 16 bits
        if (hi_r >= d_r) begin
          lo_nxt    = '1;
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end else begin
          cnt_nxt   = '0;
          state_nxt = M_DIV;
        end
      end
      M_DIV: begin
        hi_nxt  = ge ? rem[SW-1:0] : trial[SW-1:0];
        lo_nxt  = {lo_r[FIELD_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(MUL_STEPS - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    mc_r <= mc_nxt;
    d_r  <= d_nxt;
  end

  assign stat.busy = (state_r != M_IDLE);
  assign stat.done = done_r;
  assign quot_o    = lo_r;

  `PDCS_ASSERT(a_rem_below, (state_r == M_DIV) |-> (hi_r < d_r), "partial remainder reached divisor")
  `PDCS_ASSERT(a_done_idle, done_r |-> (state_r == M_IDLE), "done raised while still busy")

endmodule

FILE: hw/rtl/pwm_duty_capture_sequencer.sv
// Top level of the PWM duty capture sequencer; depends on pdcs_pkg, pdcs_if,
// pdcs_seq, pdcs_mdu and assert_macros.svh.
// Channels: in_ch takes one beat per tick, capture, query or unused item; out_ch
// returns exactly one beat per item (duty, full/empty flag, edge select,
// rearm); cfg_ch writes a register by index and is always ready.
// One item is in flight at a time. A tick, capture, query without
// recomputation, or unused mode passes through the EXEC and DONE states
// before its result is registered for out_ch.
// A query that recomputes the duty also passes through CALC, where the
// divider runs a bit-serial multiply, a range check and a restoring
// divide; a saturating quotient skips the divide.
// in_ready rises in the same cycle as the result's out_valid, so a new
// beat is taken while that result waits on out_ready.
// When the receiver stalls, the next item finishes and then holds until
// the output register frees. Reset (synchronous, active low) clears all
// measurement state and restores register defaults; no clearing pass.
`include "assert_macros.svh"

module pwm_duty_capture_sequencer import pdcs_pkg::*; #(
  parameter int STAMP_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pdcs_in_if.sink     in_ch,
  pdcs_out_if.source  out_ch,
  pdcs_cfg_if.sink    cfg_ch
);

  localparam int SW = (STAMP_BITS < FIELD_W) ? STAMP_BITS : FIELD_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  function automatic logic [SW-1:0] gap(input logic [SW-1:0] a, input logic [SW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [1:0]         state_r, state_nxt;
  logic [PPC_W-1:0]   ppc_r;
  logic [FIELD_W-1:0] recal_r, thr_r, fs_r;
  logic [MODE_W-1:0]  mode_r;
  logic [SW-1:0]      slave_r, master_r;
  logic [SW-1:0]      used_per_r, used_per_nxt;
  logic [SW-1:0]      used_dur_r, used_dur_nxt;
  logic [SW-1:0]      last_master_r, last_master_nxt;
  logic [FIELD_W-1:0] duty_r, duty_nxt;
  logic               full_r, full_nxt;
  logic               rearm_r, rearm_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_duty_r;
  logic               out_full_r, out_fall_r, out_rearm_r;
  logic               in_fire, out_fire, cfg_fire, load_out;
  logic               recompute, mdu_start;
  pdcs_cmd_t          seq_cmd;
  pdcs_seq_stat_t     seq_stat;
  pdcs_mdu_stat_t     mdu_stat;
  logic [SW-1:0]      period, duration;
  logic [FIELD_W-1:0] quot;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid & in_ch.ready;
  assign out_fire     = out_valid_r & out_ch.ready;
  assign cfg_fire     = cfg_ch.valid & cfg_ch.ready;
  assign load_out     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign seq_cmd.go   = (state_r == ST_EXEC);
  assign seq_cmd.mode = mode_r;

  pdcs_seq #(.SW(SW)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (seq_cmd),
    .slave_i    (slave_r),
    .master_i   (master_r),
    .ppc_i      (ppc_r),
    .recal_i    (recal_r),
    .stat       (seq_stat),
    .period_o   (period),
    .duration_o (duration)
  );

  pdcs_mdu #(.SW(SW)) u_mdu (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mdu_start),
    .mcand_i   (duration),
    .mplier_i  (fs_r),
    .divisor_i (period),
    .stat      (mdu_stat),
    .quot_o    (quot)
  );

  always_comb begin
    state_nxt       = state_r;
    used_per_nxt    = used_per_r;
    used_dur_nxt    = used_dur_r;
    last_master_nxt = last_master_r;
    duty_nxt        = duty_r;
    full_nxt        = full_r;
    rearm_nxt       = rearm_r;
    mdu_start       = 1'b0;
    recompute       = (FIELD_W'(gap(period, used_per_r)) >= thr_r) ||
                      (FIELD_W'(gap(duration, used_dur_r)) >= thr_r);
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        rearm_nxt = seq_stat.rearm;
        full_nxt  = 1'b0;
        state_nxt = ST_DONE;
        if (mode_r == MODE_QUERY) begin
          full_nxt        = (master_r == last_master_r);
          last_master_nxt = master_r;
          if (recompute) begin
            used_per_nxt = period;
            used_dur_nxt = duration;
            // a zero period keeps the last duty
            if (period != '0) begin
              mdu_start = 1'b1;
              state_nxt = ST_CALC;
            end
          end
        end
      end
      ST_CALC: begin
        if (mdu_stat.done) begin
          duty_nxt  = quot;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_fire) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ppc_r         <= PPC_RST;
      recal_r       <= RECAL_RST;
      thr_r         <= THR_RST;
      fs_r          <= FS_RST;
      used_per_r    <= '0;
      used_dur_r    <= '0;
      last_master_r <= '0;
      duty_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      used_per_r    <= used_per_nxt;
      used_dur_r    <= used_dur_nxt;
      last_master_r <= last_master_nxt;
      duty_r        <= duty_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_fire) begin
        unique case (cfg_ch.index)
          CFG_PPC:   ppc_r   <= cfg_ch.data[PPC_W-1:0];
          CFG_RECAL: recal_r <= cfg_ch.data;
          CFG_THR:   thr_r   <= cfg_ch.data;
          CFG_FS:    fs_r    <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    full_r  <= full_nxt;
    rearm_r <= rearm_nxt;
    if (in_fire) begin
      mode_r   <= in_ch.mode;
      slave_r  <= in_ch.slave_stamp[SW-1:0];
      master_r <= in_ch.master_stamp[SW-1:0];
    end
    if (load_out) begin
      out_duty_r  <= duty_r;
      out_full_r  <= full_r;
      out_fall_r  <= seq_stat.falling;
      out_rearm_r <= rearm_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.duty          = out_duty_r;
  assign out_ch.full_or_empty = out_full_r;
  assign out_ch.edge_falling  = out_fall_r;
  assign out_ch.rearm         = out_rearm_r;

  `PDCS_ASSERT(a_one_item, in_fire |=> !in_ch.ready, "second beat taken while an item is open")
  `PDCS_NEVER(a_mdu_scope, mdu_stat.busy && (state_r != ST_CALC), "divider running outside calc")
  `PDCS_ASSERT(a_done_calc, mdu_stat.done |-> (state_r == ST_CALC), "divider result with no owner")

endmodule

FILE: tb/testbench.sv
// Self-checking bench for pwm_duty_capture_sequencer: queue-fed burst driver, stalling
// receiver, in-bench duty predictor compared beat by beat. Needs pdcs_pkg, the
// pdcs_if interfaces and the block RTL.
module testbench import pdcs_pkg::*; ();

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] slave_stamp;
    logic [FIELD_W-1:0] master_stamp;
  } capture_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] duty;
    logic               full_or_empty;
    logic               edge_falling;
    logic               rearm;
  } duty_result_t;

  logic clk;
  logic rst_n;

  pdcs_in_if  in_ch();
  pdcs_out_if out_ch();
  pdcs_cfg_if cfg_ch();

  pwm_duty_capture_sequencer #(.STAMP_BITS(16)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  capture_item_t capture_items_q[$];
  duty_result_t  duty_results_q[$];

  int  fail_count    = 0;
  int  idle_cycles   = 0;
  bit  in_beat_taken = 1'b0;
  bit  long_hold_req = 1'b0;

  // predictor copy of the registers and measurement state
  logic [PPC_W-1:0]   cfg_ppc;
  logic [FIELD_W-1:0] cfg_recal;
  logic [FIELD_W-1:0] cfg_thr;
  logic [FIELD_W-1:0] cfg_fs;
  logic [FIELD_W-1:0] seq_cnt;
  logic               falling_sel;
  logic [FIELD_W-1:0] period_val;
  logic [FIELD_W-1:0] duration_val;
  logic [FIELD_W-1:0] used_period;
  logic [FIELD_W-1:0] used_duration;
  logic [FIELD_W-1:0] duty_val;
  logic [FIELD_W-1:0] prev_master;
  logic [FIELD_W-1:0] gen_master;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic duty_result_t next_duty_result(input logic [MODE_W-1:0] mode,
                                                     input logic [FIELD_W-1:0] slave,
                                                     input logic [FIELD_W-1:0] master);
    duty_result_t       r;
    logic [FIELD_W-1:0] diff;
    logic [FIELD_W-1:0] ppc_ext;
    logic [FIELD_W-1:0] gap_p;
    logic [FIELD_W-1:0] gap_d;
    logic [31:0]        quot;
    r       = '0;
    diff    = master - slave;
    ppc_ext = {1'b0, cfg_ppc};
    case (mode)
      MODE_TICK: begin
        if (seq_cnt == '0) begin
          falling_sel = 1'b0;
          r.rearm     = 1'b1;
          seq_cnt     = seq_cnt + 1'b1;
        end else if (seq_cnt == ppc_ext) begin
          falling_sel = 1'b1;
          r.rearm     = 1'b1;
          seq_cnt     = seq_cnt + 1'b1;
        end
      end
      MODE_CAPTURE: begin
        // at count zero or the phase boundary the tick re-arms first: drop the stamp
        if (seq_cnt != ppc_ext && seq_cnt != '0) begin
          if (seq_cnt < ppc_ext) begin
            period_val = diff;
            seq_cnt    = seq_cnt + 1'b1;
          end else begin
            if (seq_cnt > cfg_recal) seq_cnt = '0;
            else seq_cnt = seq_cnt + 1'b1;
            duration_val = diff;
          end
        end
      end
      MODE_QUERY: begin
        gap_p = (period_val >= used_period) ? period_val - used_period
                                            : used_period - period_val;
        gap_d = (duration_val >= used_duration) ? duration_val - used_duration
                                                : used_duration - duration_val;
        if (gap_p >= cfg_thr || gap_d >= cfg_thr) begin
          used_period   = period_val;
          used_duration = duration_val;
          if (period_val != '0) begin
            quot     = ({16'd0, duration_val} * {16'd0, cfg_fs}) / {16'd0, period_val};
            duty_val = (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
          end
        end
        r.full_or_empty = (master == prev_master);
        prev_master     = master;
      end
      default: begin
      end
    endcase
    r.duty         = duty_val;
    r.edge_falling = falling_sel;
    return r;
  endfunction

  task automatic push_item(input logic [MODE_W-1:0] mode, input logic [FIELD_W-1:0] slave,
                           input logic [FIELD_W-1:0] master);
    capture_item_t it;
    it.mode         = mode;
    it.slave_stamp  = slave;
    it.master_stamp = master;
    capture_items_q.push_back(it);
  endtask

  // PWM-like traffic: most captures carry period or high time plus jitter
  task automatic add_random_items(input int n, input logic [FIELD_W-1:0] per,
                                  input logic [FIELD_W-1:0] hi);
    int                 r;
    logic [FIELD_W-1:0] s;
    logic [FIELD_W-1:0] m;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      s = FIELD_W'($urandom);
      m = FIELD_W'($urandom);
      if (r < 28) begin
        push_item(MODE_TICK, s, m);
      end else if (r < 70) begin
        case ($urandom_range(0, 19))
          0, 1:   m = s;
          2, 3, 4, 5: m = FIELD_W'($urandom);
          default: m = s + ($urandom_range(0, 1) ? per : hi) + FIELD_W'($urandom_range(0, 3));
        endcase
        push_item(MODE_CAPTURE, s, m);
      end else if (r < 95) begin
        if ($urandom_range(0, 9) < 3) m = gen_master;
        gen_master = m;
        push_item(MODE_QUERY, s, m);
      end else begin
        push_item(MODE_UNUSED, s, m);
      end
    end
  endtask

  task automatic wait_drained();
    while (capture_items_q.size() != 0 || duty_results_q.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_PPC:   cfg_ppc   = data[PPC_W-1:0];
      CFG_RECAL: cfg_recal = data;
      CFG_THR:   cfg_thr   = data;
      CFG_FS:    cfg_fs    = data;
      default: begin
      end
    endcase
  endtask

  task automatic write_all_cfg(input logic [FIELD_W-1:0] ppc, input logic [FIELD_W-1:0] recal,
                               input logic [FIELD_W-1:0] thr, input logic [FIELD_W-1:0] fs);
    write_cfg(CFG_PPC, ppc);
    write_cfg(CFG_RECAL, recal);
    write_cfg(CFG_THR, thr);
    write_cfg(CFG_FS, fs);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // input side: predict each accepted beat
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      duty_results_q.push_back(next_duty_result(in_ch.mode, in_ch.slave_stamp,
                                                in_ch.master_stamp));
      in_beat_taken = 1'b1;
    end
  end

  // burst driver
  always @(negedge clk) begin : driver
    capture_item_t it;
    int            burst_left;
    int            gap_left;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_ch.valid || in_beat_taken) begin
      in_beat_taken = 1'b0;
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (capture_items_q.size() > 0) begin
        it = capture_items_q.pop_front();
        in_ch.mode         <= it.mode;
        in_ch.slave_stamp  <= it.slave_stamp;
        in_ch.master_stamp <= it.master_stamp;
        in_ch.valid        <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  always @(negedge clk) begin : receiver
    int hold_left;
    int pat_left;
    int pat_kind;
    int pat_tick;
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      if (pat_left <= 0) begin
        pat_kind = $urandom_range(0, 2);
        pat_left = $urandom_range(20, 200);
      end
      pat_left--;
      pat_tick++;
      case (pat_kind)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (pat_tick % 4 == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    duty_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (duty_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: duty=%0d foe=%0b fall=%0b rearm=%0b",
                   out_ch.duty, out_ch.full_or_empty, out_ch.edge_falling, out_ch.rearm);
      end else begin
        want = duty_results_q.pop_front();
        if (out_ch.duty !== want.duty || out_ch.full_or_empty !== want.full_or_empty ||
            out_ch.edge_falling !== want.edge_falling || out_ch.rearm !== want.rearm) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"mismatch: exp duty=%0d foe=%0b fall=%0b rearm=%0b, ",
                      "got duty=%0d foe=%0b fall=%0b rearm=%0b"},
                     want.duty, want.full_or_empty, want.edge_falling, want.rearm,
                     out_ch.duty, out_ch.full_or_empty, out_ch.edge_falling, out_ch.rearm);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [FIELD_W-1:0] per;
    logic [FIELD_W-1:0] ppc;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_TICK;
    in_ch.slave_stamp  = '0;
    in_ch.master_stamp = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_PPC;
    cfg_ch.data        = '0;
    cfg_ppc       = PPC_RST;
    cfg_recal     = RECAL_RST;
    cfg_thr       = THR_RST;
    cfg_fs        = FS_RST;
    seq_cnt       = '0;
    falling_sel   = 1'b0;
    period_val    = '0;
    duration_val  = '0;
    used_period   = '0;
    used_duration = '0;
    duty_val      = '0;
    prev_master   = '0;
    gen_master    = '0;
    rst_n         = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset settings
    push_item(MODE_CAPTURE, 16'd5, 16'd9);        // count zero: ignored
    push_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
    push_item(MODE_QUERY, 16'h0000, 16'h0000);    // same as reset stamp
    push_item(MODE_TICK, 16'h0000, 16'h0000);     // arm period phase
    push_item(MODE_TICK, 16'hFFFF, 16'hFFFF);     // mid phase: no rearm
    push_item(MODE_CAPTURE, 16'hFFFF, 16'h0000);  // wrapped difference
    push_item(MODE_CAPTURE, 16'h0000, 16'hFFFF);
    push_item(MODE_QUERY, 16'h0000, 16'hFFFF);
    push_item(MODE_QUERY, 16'hFFFF, 16'hFFFF);
    push_item(MODE_CAPTURE, 16'h1234, 16'h1234);  // zero period
    push_item(MODE_QUERY, 16'h0000, 16'h0000);
    wait_drained();

    // directed, short phases, zero threshold, top full scale
    write_all_cfg(16'd2, 16'd3, 16'd0, 16'hFFFF);
    push_item(MODE_CAPTURE, 16'h0000, 16'h8000);  // past recalibration: restart
    push_item(MODE_TICK, 16'h0000, 16'h0000);
    push_item(MODE_CAPTURE, 16'h0010, 16'h0011);  // period of one
    push_item(MODE_TICK, 16'h0000, 16'h0000);     // arm duration phase
    push_item(MODE_QUERY, 16'h0000, 16'h0005);    // saturates
    push_item(MODE_CAPTURE, 16'h0000, 16'h0100);
    push_item(MODE_CAPTURE, 16'h0000, 16'h0200);
    push_item(MODE_QUERY, 16'hFFFF, 16'h0005);
    push_item(MODE_CAPTURE, 16'h0000, 16'h0300);  // count zero again: ignored
    push_item(MODE_QUERY, 16'h0000, 16'h0006);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all_cfg(16'd3, 16'd12, 16'd1, 16'd1000);
        1: write_all_cfg(16'd1, 16'd2, 16'hFFFF, 16'd1);
        2: write_all_cfg(16'h7FFF, 16'hFFFE, 16'd0, 16'hFFFF);
        3: begin
          ppc = FIELD_W'($urandom_range(2, 8));
          write_all_cfg(ppc, ppc + FIELD_W'($urandom_range(0, 20)),
                        FIELD_W'($urandom_range(0, 8)), FIELD_W'($urandom_range(1, 65535)));
        end
        4: write_all_cfg(16'd5, 16'd30, 16'd2, 16'd1000);
        default: write_all_cfg(16'd4, 16'd2, 16'd3, 16'd100);  // recal below phase count
      endcase
      if (ph == 3) long_hold_req = 1'b1;
      per = (ph == 2) ? FIELD_W'($urandom_range(100, 60000))
                      : FIELD_W'($urandom_range(2, 2000));
      add_random_items(100, per, FIELD_W'($urandom_range(0, per)));
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
